@@ hw/rtl/per_address_rate_limiter_top_defines.svh @@
// ----------------------------------------------------------------------------
// per_address_rate_limiter_top_defines.svh
// Assertion macros for the per-address rate limiter.
// ----------------------------------------------------------------------------
`ifndef PER_ADDRESS_RATE_LIMITER_TOP_DEFINES_SVH
`define PER_ADDRESS_RATE_LIMITER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Check an implication property on every rising edge outside reset.
`define PRL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define PRL_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define PRL_ASSERT(lbl, clk, rstn, prop, msg)
`define PRL_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

@@ hw/rtl/prl_pkg.sv @@
// ----------------------------------------------------------------------------
// prl_pkg
// Types and constants shared by the rate limiter modules.
// ----------------------------------------------------------------------------
package prl_pkg;

  localparam logic [7:0] LIMIT_RESET = 8'd10;
  localparam logic [7:0] COUNT_MAX   = 8'hFF;
  localparam int unsigned SLOT_W     = 6;

  typedef struct packed {
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic        is_ipv6;
    logic [31:0] now_seconds;
  } prl_in_t;

  typedef struct packed {
    logic              allowed;
    logic              tracked;
    logic [SLOT_W-1:0] slot;
  } prl_out_t;

  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic        v6;
  } prl_key_t;

  typedef struct packed {
    prl_key_t    key;
    logic [31:0] win;
    logic [7:0]  cnt;
  } prl_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic start;   // latch the item, restart the scan
    logic scan;    // issue one table read, advance the pointer
    logic hit_wr;  // update the matched entry, load the result
    logic miss_wr; // insert or drop the new address, load the result
  } prl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic more;     // entries left to read
    logic match;    // entry under compare matches the key
    logic out_free; // result register can take a new item
  } prl_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_MISS
  } prl_state_e;

endpackage

@@ hw/rtl/prl_ctrl.sv @@
// ----------------------------------------------------------------------------
// prl_ctrl
// Sequencer for the rate limiter: accept, scan the table, update, respond.
// ----------------------------------------------------------------------------
module prl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  prl_pkg::prl_sts_t sts_i,
  output prl_pkg::prl_cmd_t cmd_o
);
  import prl_pkg::*;

  prl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.match) begin
          state_d = ST_HIT;
        end else begin
          cmd_o.scan = 1'b1;
          if (!sts_i.more) begin
            state_d = ST_MISS;
          end
        end
      end
      ST_HIT: begin
        if (sts_i.out_free) begin
          cmd_o.hit_wr = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_MISS: begin
        if (sts_i.out_free) begin
          cmd_o.miss_wr = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/prl_dp.sv @@
// ----------------------------------------------------------------------------
// prl_dp
// Datapath: address table, scan pointer, window update and result register.
// ----------------------------------------------------------------------------
module prl_dp #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  prl_pkg::prl_in_t   in_data_i,
  input  logic               cfg_valid_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output prl_pkg::prl_out_t  out_data_o,
  input  prl_pkg::prl_cmd_t  cmd_i,
  output prl_pkg::prl_sts_t  sts_o
);
  import prl_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  prl_entry_t       mem [TABLE_ENTRIES];
  prl_entry_t       rdata_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             cmp_vld_q;
  logic [CNT_W-1:0] scan_idx_q;
  logic [CNT_W-1:0] used_q;
  logic [7:0]       limit_q;
  prl_key_t         key_q;
  logic [31:0]      now_q;
  logic             out_valid_q;
  prl_out_t         out_q;

  logic             more;
  logic             full;
  logic             match;
  logic             issue;
  logic [7:0]       cnt_base;
  logic [7:0]       cnt_new;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  prl_entry_t       mem_wdata;
  prl_out_t         res;

  assign more  = scan_idx_q < used_q;
  assign full  = used_q == CNT_W'(TABLE_ENTRIES);
  assign match = cmp_vld_q && (rdata_q.key == key_q);
  assign issue = cmd_i.scan && more;

  assign sts_o.more     = more;
  assign sts_o.match    = match;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Restart the window on any change of second, then count with saturation.
  assign cnt_base = (rdata_q.win == now_q) ? rdata_q.cnt : 8'd0;
  assign cnt_new  = (cnt_base == COUNT_MAX) ? cnt_base : cnt_base + 8'd1;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cmp_idx_q;
    mem_wdata = '{key: key_q, win: now_q, cnt: cnt_new};
    res       = '{allowed: 1'b1, tracked: 1'b0, slot: '0};
    if (cmd_i.hit_wr) begin
      mem_we      = 1'b1;
      res.allowed = cnt_new <= limit_q;
      res.tracked = 1'b1;
      res.slot    = SLOT_W'(cmp_idx_q);
    end else if (cmd_i.miss_wr && !full) begin
      mem_we        = 1'b1;
      mem_waddr     = used_q[IDX_W-1:0];
      mem_wdata.cnt = 8'd1;
      res.tracked   = 1'b1;
      res.slot      = SLOT_W'(used_q[IDX_W-1:0]);
    end
  end

  // Table storage, one read and one write port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rdata_q   <= mem[scan_idx_q[IDX_W-1:0]];
      cmp_idx_q <= scan_idx_q[IDX_W-1:0];
    end
  end

  // Latch the item with IPv4 stray bits cleared.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q.v6      <= in_data_i.is_ipv6;
      key_q.addr_hi <= in_data_i.is_ipv6 ? in_data_i.address_high : 64'd0;
      key_q.addr_lo <= in_data_i.is_ipv6 ? in_data_i.address_low
                                         : {32'd0, in_data_i.address_low[31:0]};
      now_q         <= in_data_i.now_seconds;
    end
    if (cmd_i.hit_wr || cmd_i.miss_wr) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q  <= '0;
      cmp_vld_q   <= 1'b0;
      used_q      <= '0;
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        scan_idx_q <= '0;
        cmp_vld_q  <= 1'b0;
      end else if (cmd_i.scan) begin
        cmp_vld_q <= more;
        if (more) begin
          scan_idx_q <= scan_idx_q + CNT_W'(1);
        end
      end
      if (cmd_i.miss_wr && !full) begin
        used_q <= used_q + CNT_W'(1);
      end
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (cmd_i.hit_wr || cmd_i.miss_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/per_address_rate_limiter_top.sv @@
// ----------------------------------------------------------------------------
// per_address_rate_limiter_top
// Fixed-window request limiter keyed by client address (IPv4 or IPv6).
// Sequence: the scan reads the used entries until one matches, one entry per
//   cycle through one read port; a hit updates that entry and a miss inserts
//   the address if the table has room. Throughput: one item at a time; the
//   result waits for a free result register and the input reopens once it is loaded.
// Reset: clears the entry count, the scan control and the result valid flag,
//   and loads the limit with 10; table contents are left as they are.
// ----------------------------------------------------------------------------
`include "per_address_rate_limiter_top_defines.svh"

module per_address_rate_limiter_top #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request items
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  prl_pkg::prl_in_t  in_data_i,
  // result items
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output prl_pkg::prl_out_t out_data_o,
  // limit register write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_data_i
);
  import prl_pkg::*;

  prl_cmd_t cmd;
  prl_sts_t sts;

  // The limit register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // Sequencer: idle, scan the used part of the table, then update or insert.
  prl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table, compare, window and count update, result register.
  prl_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // A result is only loaded when the result register can take it.
  `PRL_ASSERT(a_load_when_free, clk_i, rst_ni, (cmd.hit_wr || cmd.miss_wr) |-> sts.out_free, "result loaded over a pending item")

  // A new result appears only right after an update step.
  `PRL_ASSERT(a_out_after_update, clk_i, rst_ni, $rose(out_valid_o) |-> $past(cmd.hit_wr || cmd.miss_wr), "result shown without an update")

  // An accepted item closes the input until its result is loaded.
  `PRL_ASSERT(a_one_in_flight, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "second item accepted during a scan")

  // Hit and insert never happen together.
  `PRL_ASSERT_NEVER(a_hit_miss_excl, clk_i, rst_ni, cmd.hit_wr && cmd.miss_wr, "hit and insert in one cycle")

endmodule

@@ verif/per_address_rate_limiter_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_address_rate_limiter_top_tb
// Self-checking bench for the per-address rate limiter. A scripted opening
// covers address identity, stray IPv4 bits, limit extremes and time steps in
// both directions. It is followed by a saturation burst on one address and
// random traffic that fills the table and goes past it. A behavioral
// predictor scores every result in order under random stalls on both sides.
// ----------------------------------------------------------------------------
module per_address_rate_limiter_top_tb;
  import prl_pkg::*;

  localparam int          TABLE_ENTRIES = 64;
  localparam int          STALL_LIMIT   = 2000;
  localparam logic [63:0] HOST_A        = 64'h0000_0000_0A00_0001;
  localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [0:0] {
    ROW_REQUEST,
    ROW_LIMIT
  } row_kind_e;

  typedef struct {
    row_kind_e  kind;
    prl_in_t    req;
    logic [7:0] limit;
    bit         typed;
    prl_out_t   result;
  } script_row_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  prl_in_t  in_data   = '0;
  logic     out_ready = 1'b0;
  logic     cfg_valid = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  logic     in_ready;
  logic     out_valid;
  logic     cfg_ready;
  prl_out_t out_data;

  // Predictor copy of the address table and the limit register.
  logic [63:0] seen_hi     [TABLE_ENTRIES];
  logic [63:0] seen_lo     [TABLE_ENTRIES];
  logic        seen_v6     [TABLE_ENTRIES];
  logic [31:0] seen_second [TABLE_ENTRIES];
  logic [7:0]  seen_count  [TABLE_ENTRIES];
  int          seen_used  = 0;
  logic [7:0]  limit_shadow = LIMIT_RESET;

  prl_out_t    expected_verdicts[$];
  prl_in_t     clients[$];
  script_row_t script[$];
  logic [31:0] sim_second = 32'd1000;

  int feed_idle_pct = 0;
  int take_idle_pct = 0;
  int mismatches    = 0;
  int requests_sent = 0;
  int blocked_seen  = 0;
  int untracked_seen = 0;
  int limit_writes  = 0;
  int quiet_cycles  = 0;

  per_address_rate_limiter_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk = ~clk;

  // Work out the verdict for one request and update the table copy.
  function automatic prl_out_t rate_verdict(input prl_in_t req);
    logic [63:0] hi;
    logic [63:0] lo;
    prl_out_t    res;
    int          hit;
    // IPv4 keys ignore everything above the low 32 bits.
    hi  = req.is_ipv6 ? req.address_high : 64'd0;
    lo  = req.is_ipv6 ? req.address_low : {32'd0, req.address_low[31:0]};
    hit = -1;
    for (int i = 0; i < seen_used; i++) begin
      if (hit < 0 && seen_v6[i] == req.is_ipv6 && seen_hi[i] == hi && seen_lo[i] == lo) begin
        hit = i;
      end
    end
    if (hit >= 0) begin
      // Any change of second, forward or back, restarts the window.
      if (seen_second[hit] != req.now_seconds) begin
        seen_second[hit] = req.now_seconds;
        seen_count[hit]  = 8'd0;
      end
      if (seen_count[hit] != COUNT_MAX) begin
        seen_count[hit] = seen_count[hit] + 8'd1;
      end
      res.allowed = (seen_count[hit] <= limit_shadow);
      res.tracked = 1'b1;
      res.slot    = hit[5:0];
    end else if (seen_used < TABLE_ENTRIES) begin
      seen_hi[seen_used]     = hi;
      seen_lo[seen_used]     = lo;
      seen_v6[seen_used]     = req.is_ipv6;
      seen_second[seen_used] = req.now_seconds;
      seen_count[seen_used]  = 8'd1;
      res.allowed = 1'b1;
      res.tracked = 1'b1;
      res.slot    = seen_used[5:0];
      seen_used++;
    end else begin
      // Table full: let the new address through untracked.
      res.allowed = 1'b1;
      res.tracked = 1'b0;
      res.slot    = '0;
    end
    return res;
  endfunction

  function automatic script_row_t request_row(input logic [63:0] hi, input logic [63:0] lo,
                                              input logic v6, input logic [31:0] sec,
                                              input bit typed, input logic ok,
                                              input logic trk, input logic [5:0] slot);
    script_row_t row;
    row.kind               = ROW_REQUEST;
    row.req.address_high   = hi;
    row.req.address_low    = lo;
    row.req.is_ipv6        = v6;
    row.req.now_seconds    = sec;
    row.limit              = 8'd0;
    row.typed              = typed;
    row.result.allowed     = ok;
    row.result.tracked     = trk;
    row.result.slot        = slot;
    return row;
  endfunction

  function automatic script_row_t limit_row(input logic [7:0] value);
    script_row_t row;
    row.kind   = ROW_LIMIT;
    row.req    = '0;
    row.limit  = value;
    row.typed  = 1'b0;
    row.result = '0;
    return row;
  endfunction

  // Drop valid and hold until every pending result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_limit(input logic [7:0] value);
    wait_drained();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    limit_shadow = value;
    limit_writes++;
  endtask

  // Present one request, hold it until taken, then log its verdict.
  task automatic send_request(input prl_in_t req, input bit typed, input prl_out_t typed_res);
    prl_out_t want;
    while ($urandom_range(99) < feed_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    want = rate_verdict(req);
    if (typed) want = typed_res;
    expected_verdicts.push_back(want);
    requests_sent++;
    if (!want.allowed) blocked_seen++;
    if (!want.tracked) untracked_seen++;
  endtask

  // Random traffic: mostly repeat clients, a hot few of them, some new ones.
  task automatic run_traffic(input int n);
    prl_in_t req;
    int      pick;
    int      hot;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (clients.size() == 0 || pick < 18) begin
        req.is_ipv6      = 1'($urandom_range(1));
        req.address_high = {$urandom, $urandom};
        req.address_low  = {$urandom, $urandom};
        clients.push_back(req);
      end else if (pick < 60) begin
        hot = (clients.size() > 4) ? 3 : clients.size() - 1;
        req = clients[clients.size() - 1 - $urandom_range(hot)];
      end else begin
        req = clients[$urandom_range(clients.size() - 1)];
      end
      // Scramble the bits an IPv4 key ignores.
      if (!req.is_ipv6 && $urandom_range(1)) begin
        req.address_high       = {$urandom, $urandom};
        req.address_low[63:32] = $urandom;
      end
      pick = $urandom_range(99);
      if (pick < 20) begin
        sim_second = sim_second + 32'd1;
      end else if (pick < 24) begin
        sim_second = sim_second - $urandom_range(3, 1);
      end else if (pick < 27) begin
        sim_second = $urandom;
      end
      req.now_seconds = sim_second;
      // Occasionally let the pipe run dry before the next request.
      if ($urandom_range(39) == 0) wait_drained();
      send_request(req, 1'b0, '0);
    end
  endtask

  // Result side: random back-pressure and in-order scoring.
  always @(posedge clk) begin
    prl_out_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        if (mismatches < 10) begin
          $display("%0t: unexpected result allowed=%0b tracked=%0b slot=%0d",
                   $realtime, out_data.allowed, out_data.tracked, out_data.slot);
        end
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_data.allowed !== want.allowed || out_data.tracked !== want.tracked ||
            out_data.slot !== want.slot) begin
          if (mismatches < 10) begin
            $display("%0t: result mismatch: expected allowed=%0b tracked=%0b slot=%0d",
                     $realtime, want.allowed, want.tracked, want.slot);
            $display("%0t:                  got      allowed=%0b tracked=%0b slot=%0d",
                     $realtime, out_data.allowed, out_data.tracked, out_data.slot);
          end
          mismatches++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= take_idle_pct);
  end

  // Watchdog: end the run if no item moves on any channel for too long.
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
          (cfg_valid && cfg_ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    prl_in_t burst;

    // Opening script, limit starts at its reset value of 10.
    script.push_back(request_row(64'd0, HOST_A, 1'b0, 32'd100, 1'b1, 1'b1, 1'b1, 6'd0));
    // Same IPv4 host with junk in the ignored bits must hit entry 0.
    script.push_back(request_row(ALL_ONES, {32'hFFFF_FFFF, HOST_A[31:0]}, 1'b0, 32'd100,
                                 1'b1, 1'b1, 1'b1, 6'd0));
    // Same 128-bit value flagged IPv6 is a different key.
    script.push_back(request_row(64'd0, HOST_A, 1'b1, 32'd100, 1'b1, 1'b1, 1'b1, 6'd1));
    script.push_back(request_row(ALL_ONES, ALL_ONES, 1'b1, 32'hFFFF_FFFF,
                                 1'b1, 1'b1, 1'b1, 6'd2));
    script.push_back(request_row(64'd0, 64'd0, 1'b0, 32'd0, 1'b1, 1'b1, 1'b1, 6'd3));
    script.push_back(request_row(64'd0, 64'd0, 1'b1, 32'd0, 1'b1, 1'b1, 1'b1, 6'd4));
    script.push_back(request_row(64'd0, 64'h0000_0000_FFFF_FFFF, 1'b0, 32'd0,
                                 1'b1, 1'b1, 1'b1, 6'd5));
    script.push_back(limit_row(8'd1));
    script.push_back(request_row(64'd0, HOST_A, 1'b0, 32'd100, 1'b0, 1'b0, 1'b0, 6'd0));
    // Time steps back a second: window restarts.
    script.push_back(request_row(64'd0, HOST_A, 1'b0, 32'd99, 1'b0, 1'b0, 1'b0, 6'd0));
    script.push_back(request_row(64'd0, HOST_A, 1'b0, 32'd99, 1'b0, 1'b0, 1'b0, 6'd0));
    script.push_back(request_row(64'd0, HOST_A, 1'b1, 32'd100, 1'b0, 1'b0, 1'b0, 6'd0));
    // Limit of zero blocks every known address.
    script.push_back(limit_row(8'd0));
    script.push_back(request_row(ALL_ONES, ALL_ONES, 1'b1, 32'hFFFF_FFFF,
                                 1'b1, 1'b0, 1'b1, 6'd2));
    script.push_back(request_row(64'd0, 64'd0, 1'b0, 32'd1, 1'b1, 1'b0, 1'b1, 6'd3));
    script.push_back(request_row(64'h8000_0000_0000_0000, 64'd1, 1'b1, 32'd7,
                                 1'b1, 1'b1, 1'b1, 6'd6));
    script.push_back(limit_row(8'd255));
    script.push_back(request_row(64'd0, HOST_A, 1'b0, 32'd99, 1'b0, 1'b0, 1'b0, 6'd0));
    script.push_back(request_row(64'd0, 64'd0, 1'b1, 32'd0, 1'b0, 1'b0, 1'b0, 6'd0));
    script.push_back(limit_row(8'd10));

    feed_idle_pct = 17;
    take_idle_pct = 60;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[r]) begin
      if (script[r].kind == ROW_LIMIT) begin
        set_limit(script[r].limit);
      end else begin
        clients.push_back(script[r].req);
        send_request(script[r].req, script[r].typed, script[r].result);
      end
    end

    set_limit(8'd3);
    run_traffic(220);

    // Saturation: hammer one host within one second past a count of 255.
    feed_idle_pct = 60;
    take_idle_pct = 17;
    set_limit(8'd254);
    burst.address_high = 64'd0;
    burst.address_low  = HOST_A;
    burst.is_ipv6      = 1'b0;
    burst.now_seconds  = 32'h5A5A_0000;
    repeat (256) send_request(burst, 1'b0, '0);
    set_limit(8'd255);
    repeat (2) send_request(burst, 1'b0, '0);

    set_limit(8'd1);
    run_traffic(200);

    // Full rate on both sides with random limits.
    feed_idle_pct = 0;
    take_idle_pct = 0;
    set_limit(8'($urandom_range(254, 1)));
    run_traffic(120);
    set_limit(8'($urandom_range(254, 1)));
    run_traffic(130);

    wait_drained();
    repeat (2 * (TABLE_ENTRIES + 3)) @(posedge clk);

    $display("Covered %0d requests under %0d limit writes: %0d blocked, %0d untracked.",
             requests_sent, limit_writes, blocked_seen, untracked_seen);
    $display("Table entries filled: %0d; count saturation and backward time exercised.",
             seen_used);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches,
               expected_verdicts.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/prl_pkg.sv
hw/rtl/prl_ctrl.sv
hw/rtl/prl_dp.sv
hw/rtl/per_address_rate_limiter_top.sv
verif/per_address_rate_limiter_top_tb.sv
